[design/fcst_pkg.sv]
// ---------------------------------------------------------------------------
// fcst_pkg
// Shared types and constants for the floor and ceiling span texturer.
// ---------------------------------------------------------------------------
package fcst_pkg;

   // texture geometry
   localparam int TEX_W     = 64;
   localparam int TEX_H     = 64;
   localparam int TEX_DEPTH = 4096;
   localparam int TEX_AW    = $clog2(TEX_DEPTH);
   localparam int TEX_XW    = $clog2(TEX_W);
   localparam int TEX_YW    = $clog2(TEX_H);
   localparam logic [23:0] HALF_MASK = 24'h7F7F7F;

   // divider geometry
   localparam int DIV_NW = 32;
   localparam int DIV_DW = 12;
   localparam int DIV_CW = $clog2(DIV_NW);

   // request actions
   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_ROW   = 2'd1,
      ACT_PIXEL = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_CAMERA_POSITION = 3'd0,
      CSR_DIR_X           = 3'd1,
      CSR_DIR_Y           = 3'd2,
      CSR_PLANE_X         = 3'd3,
      CSR_PLANE_Y         = 3'd4,
      CSR_SCREEN_WIDTH    = 3'd5,
      CSR_SCREEN_HEIGHT   = 3'd6,
      CSR_CEILING_COLOR   = 3'd7
   } csr_type;

   // row setup terms, in the order they are produced
   typedef enum logic [1:0] {
      TERM_STEP_X  = 2'd0,
      TERM_STEP_Y  = 2'd1,
      TERM_COORD_X = 2'd2,
      TERM_COORD_Y = 2'd3
   } term_type;

   // divider operand selection
   typedef enum logic {
      DIV_DST  = 1'b0,
      DIV_STEP = 1'b1
   } div_sel_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DST_DIV,
      ST_MUL,
      ST_USE,
      ST_STEP_DIV
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic        tex_write;
      logic        pix_issue;
      logic        row_load;
      logic        horizon_load;
      logic        div_start;
      div_sel_type div_sel;
      logic        dst_load;
      logic        mul_load;
      logic        step_load;
      logic        coord_load;
      term_type    term;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic p_zero;
      logic div_done;
      logic pix_ok;
      logic pend_block;
   } status_type;

endpackage

[design/floor_ceiling_span_texturer_core.sv]
// ---------------------------------------------------------------------------
// floor_ceiling_span_texturer_core
// Horizontal floor casting: texel store, row setup and pixel pair stream.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   action, row, texel_index, texel_color
//   rsp      out        rsp_valid / rsp_stall   column, rows, colors, flags
//   csr      in         csr_write_en            csr_index, csr_data
//
// texel writes and next-pixel requests are taken from idle; a pixel result
// passes the pending stage and the result register, then results follow one
// per cycle while rsp_stall is low; start row: a check, the distance divide,
// then a multiply and a divide per step and a multiply per coordinate, with
// every divide on the single bit-serial divider (a horizon row ends at the check)
// reset is synchronous; texture contents are not cleared
// a stalled result holds the pending pixel; the next request then waits
// ---------------------------------------------------------------------------
module floor_ceiling_span_texturer_core
   import fcst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [10:0] req_row,
   input  logic [11:0] req_texel_index,
   input  logic [23:0] req_texel_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_column,
   output logic [10:0] rsp_floor_row,
   output logic [23:0] rsp_floor_color,
   output logic [10:0] rsp_ceiling_row,
   output logic [23:0] rsp_ceiling_out_color,
   output logic        rsp_last_in_row,
   output logic        rsp_horizon_row,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);

   cmd_type    cmd;
   status_type status;
   state_type  state;

   // controller
   fcst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd),
      .state      (state)
   );

   // datapath
   fcst_datapath u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_row               (req_row),
      .req_texel_index       (req_texel_index),
      .req_texel_color       (req_texel_color),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_column            (rsp_column),
      .rsp_floor_row         (rsp_floor_row),
      .rsp_floor_color       (rsp_floor_color),
      .rsp_ceiling_row       (rsp_ceiling_row),
      .rsp_ceiling_out_color (rsp_ceiling_out_color),
      .rsp_last_in_row       (rsp_last_in_row),
      .rsp_horizon_row       (rsp_horizon_row)
   );

   // a held result keeps its pixel
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_column))
      else $error("held result changed");

   // a start-row request makes the block busy
   a_row_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == ACT_ROW |=> req_stall)
      else $error("row setup did not stall requests");

   // pixels are only issued from idle
   a_pix_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.pix_issue |-> state == ST_IDLE && status.pix_ok)
      else $error("pixel issued outside idle");

endmodule

[design/fcst_ram.sv]
// ---------------------------------------------------------------------------
// fcst_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module fcst_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/fcst_div.sv]
// ---------------------------------------------------------------------------
// fcst_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fcst_div
   import fcst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] dividend,
   input  logic [DIV_DW-1:0] divisor,
   output logic              done,
   output logic [DIV_NW-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] dvs_ff, dvs_in;
   logic [DIV_DW:0]   trial;

   // one shift and subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_NW-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DIV_DW'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DW-1:0];
            quo_in = {quo_ff[DIV_NW-2:0], 1'b0};
         end
         cnt_in = DIV_CW'(cnt_ff + 1'b1);
         if (cnt_ff == DIV_CW'(DIV_NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operand state
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[design/fcst_datapath.sv]
// ---------------------------------------------------------------------------
// fcst_datapath
// Configuration, row setup arithmetic, texture memory and result register.
// ---------------------------------------------------------------------------
module fcst_datapath
   import fcst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [10:0] req_row,
   input  logic [11:0] req_texel_index,
   input  logic [23:0] req_texel_color,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_column,
   output logic [10:0] rsp_floor_row,
   output logic [23:0] rsp_floor_color,
   output logic [10:0] rsp_ceiling_row,
   output logic [23:0] rsp_ceiling_out_color,
   output logic        rsp_last_in_row,
   output logic        rsp_horizon_row
);

   // configuration registers
   logic        [47:0] cam_ff;
   logic signed [17:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic        [11:0] width_ff, height_ff;
   logic        [23:0] ceil_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff     <= '0;
         dir_x_ff   <= 18'sd65536;
         dir_y_ff   <= '0;
         plane_x_ff <= '0;
         plane_y_ff <= 18'sd43253;
         width_ff   <= 12'd640;
         height_ff  <= 12'd480;
         ceil_ff    <= '0;
      end else if (csr_write_en) begin
         unique case (csr_type'(csr_index))
            CSR_CAMERA_POSITION: cam_ff     <= csr_data;
            CSR_DIR_X:           dir_x_ff   <= csr_data[17:0];
            CSR_DIR_Y:           dir_y_ff   <= csr_data[17:0];
            CSR_PLANE_X:         plane_x_ff <= csr_data[17:0];
            CSR_PLANE_Y:         plane_y_ff <= csr_data[17:0];
            CSR_SCREEN_WIDTH:    width_ff   <= csr_data[11:0];
            CSR_SCREEN_HEIGHT:   height_ff  <= csr_data[11:0];
            CSR_CEILING_COLOR:   ceil_ff    <= csr_data[23:0];
            default:             cam_ff     <= cam_ff;
         endcase
      end
   end

   // span state
   logic        [31:0] fx_ff, fy_ff, sx_ff, sy_ff;
   logic        [11:0] col_ff;
   logic        [10:0] row_ff;
   logic               hor_ff;
   logic signed [11:0] p_ff;
   logic signed [27:0] dst_ff;
   logic signed [46:0] prod_ff;

   // row setup operands
   logic        [10:0] p_mag;
   logic        [11:0] width_div;
   logic signed [18:0] mul_op;
   logic        [46:0] prod_abs;
   logic        [29:0] prod_mag;
   logic        [31:0] term_val;
   logic        [31:0] div_num;
   logic        [11:0] div_den;
   logic               div_done;
   logic        [31:0] div_quo;

   assign p_mag     = p_ff[11] ? 11'(-p_ff) : p_ff[10:0];
   assign width_div = (width_ff == 12'd0) ? 12'd1 : width_ff;

   // multiplier operand per term
   always_comb begin
      case (cmd.term)
         TERM_STEP_X:  mul_op = {plane_x_ff, 1'b0};
         TERM_STEP_Y:  mul_op = {plane_y_ff, 1'b0};
         TERM_COORD_X: mul_op = 19'(dir_x_ff) - 19'(plane_x_ff);
         default:      mul_op = 19'(dir_y_ff) - 19'(plane_y_ff);
      endcase
   end

   // magnitude of product scaled down by 2^16, truncated toward zero
   assign prod_abs = prod_ff[46] ? 47'(-prod_ff) : 47'(prod_ff);
   assign prod_mag = prod_abs[45:16];
   assign term_val = prod_ff[46] ? 32'(-{2'b00, prod_mag}) : {2'b00, prod_mag};

   // divider operands
   always_comb begin
      case (cmd.div_sel)
         DIV_DST: begin
            div_num = {5'd0, height_ff, 15'd0};
            div_den = {1'b0, p_mag};
         end
         default: begin
            div_num = {2'b00, prod_mag};
            div_den = width_div;
         end
      endcase
   end

   fcst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // setup arithmetic registers
   always_ff @(posedge clock) begin
      if (cmd.row_load) begin
         p_ff <= $signed({1'b0, req_row}) - $signed({1'b0, height_ff[11:1]});
      end
      if (cmd.dst_load) begin
         dst_ff <= p_ff[11] ? 28'(-{1'b0, div_quo[26:0]}) : {1'b0, div_quo[26:0]};
      end
      if (cmd.mul_load) begin
         prod_ff <= 47'(dst_ff * mul_op);
      end
   end

   // texture address from coordinate fraction bits
   logic [15+TEX_XW:0] tx_prod;
   logic [15+TEX_YW:0] ty_prod;
   logic [31:0]        tex_full;
   logic [TEX_AW-1:0]  rd_addr;
   logic [23:0]        texel;

   assign tx_prod  = (16+TEX_XW)'(fx_ff[15:0]) * (16+TEX_XW)'(TEX_W);
   assign ty_prod  = (16+TEX_YW)'(fy_ff[15:0]) * (16+TEX_YW)'(TEX_H);
   assign tex_full = 32'(TEX_W) * 32'(ty_prod[15+TEX_YW:16]) + 32'(tx_prod[15+TEX_XW:16]);
   assign rd_addr  = tex_full[TEX_AW-1:0];

   fcst_ram #(
      .WIDTH (24),
      .DEPTH (TEX_DEPTH)
   ) u_tex_ram (
      .clock   (clock),
      .wr_en   (cmd.tex_write),
      .wr_addr (req_texel_index[TEX_AW-1:0]),
      .wr_data (req_texel_color),
      .rd_en   (cmd.pix_issue),
      .rd_addr (rd_addr),
      .rd_data (texel)
   );

   // span registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fx_ff  <= '0;
         fy_ff  <= '0;
         sx_ff  <= '0;
         sy_ff  <= '0;
         col_ff <= '0;
         row_ff <= '0;
         hor_ff <= 1'b0;
      end else begin
         if (cmd.row_load) begin
            row_ff <= req_row;
            col_ff <= '0;
         end
         if (cmd.horizon_load) begin
            hor_ff <= 1'b1;
            sx_ff  <= '0;
            sy_ff  <= '0;
            fx_ff  <= {8'd0, cam_ff[23:0]};
            fy_ff  <= {8'd0, cam_ff[47:24]};
         end
         if (cmd.dst_load) begin
            hor_ff <= 1'b0;
         end
         // product already carries the sign of the distance
         if (cmd.step_load) begin
            if (cmd.term == TERM_STEP_X) begin
               sx_ff <= prod_ff[46] ? 32'(-div_quo) : div_quo;
            end else begin
               sy_ff <= prod_ff[46] ? 32'(-div_quo) : div_quo;
            end
         end
         if (cmd.coord_load) begin
            if (cmd.term == TERM_COORD_X) begin
               fx_ff <= {8'd0, cam_ff[23:0]} + term_val;
            end else begin
               fy_ff <= {8'd0, cam_ff[47:24]} + term_val;
            end
         end
         if (cmd.pix_issue) begin
            fx_ff  <= fx_ff + sx_ff;
            fy_ff  <= fy_ff + sy_ff;
            col_ff <= col_ff + 12'd1;
         end
      end
   end

   // pending stage waits for the texel read
   logic        pend_ff, pend_move;
   logic [10:0] pcol_ff, prow_ff, pceil_row_ff;
   logic [23:0] pceil_ff;
   logic        plast_ff, phor_ff;
   logic        out_ff;

   assign pend_move = pend_ff && (!out_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         out_ff  <= 1'b0;
      end else begin
         if (cmd.pix_issue) begin
            pend_ff <= 1'b1;
         end else if (pend_move) begin
            pend_ff <= 1'b0;
         end
         if (pend_move) begin
            out_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pix_issue) begin
         pcol_ff      <= col_ff[10:0];
         prow_ff      <= row_ff;
         pceil_row_ff <= 11'(height_ff - {1'b0, row_ff} - 12'd1);
         pceil_ff     <= ceil_ff;
         plast_ff     <= (col_ff == 12'(width_ff - 12'd1));
         phor_ff      <= hor_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (pend_move) begin
         rsp_column            <= pcol_ff;
         rsp_floor_row         <= prow_ff;
         rsp_floor_color       <= (texel >> 1) & HALF_MASK;
         rsp_ceiling_row       <= pceil_row_ff;
         rsp_ceiling_out_color <= pceil_ff;
         rsp_last_in_row       <= plast_ff;
         rsp_horizon_row       <= phor_ff;
      end
   end

   assign rsp_valid         = out_ff;
   assign status.p_zero     = (p_ff == 12'sd0);
   assign status.div_done   = div_done;
   assign status.pix_ok     = (col_ff < width_ff);
   assign status.pend_block = pend_ff && !pend_move;

endmodule

[design/fcst_ctrl.sv]
// ---------------------------------------------------------------------------
// fcst_ctrl
// Sequencer for request decode and row setup.
// ---------------------------------------------------------------------------
module fcst_ctrl
   import fcst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_action,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd,
   output state_type  state
);

   state_type state_ff, state_in;
   term_type  term_ff, term_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE) || status.pend_block;
   assign accept    = req_valid && !req_stall;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff  <= TERM_STEP_X;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      term_in     = term_ff;
      cmd         = '0;
      cmd.term    = term_ff;
      cmd.div_sel = DIV_STEP;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (action_type'(req_action))
                  ACT_WRITE: cmd.tex_write = 1'b1;
                  ACT_ROW: begin
                     cmd.row_load = 1'b1;
                     state_in     = ST_CHECK;
                  end
                  ACT_PIXEL: cmd.pix_issue = status.pix_ok;
                  default:   cmd.pix_issue = 1'b0;
               endcase
            end
         end
         ST_CHECK: begin
            if (status.p_zero) begin
               cmd.horizon_load = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_DST;
               state_in      = ST_DST_DIV;
            end
         end
         ST_DST_DIV: begin
            if (status.div_done) begin
               cmd.dst_load = 1'b1;
               term_in      = TERM_STEP_X;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_USE;
         end
         ST_USE: begin
            if (term_ff == TERM_STEP_X || term_ff == TERM_STEP_Y) begin
               cmd.div_start = 1'b1;
               state_in      = ST_STEP_DIV;
            end else begin
               cmd.coord_load = 1'b1;
               term_in        = term_type'(term_ff + 2'd1);
               state_in       = (term_ff == TERM_COORD_Y) ? ST_IDLE : ST_MUL;
            end
         end
         ST_STEP_DIV: begin
            if (status.div_done) begin
               cmd.step_load = 1'b1;
               term_in       = term_type'(term_ff + 2'd1);
               state_in      = ST_MUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign state = state_ff;

endmodule
